@@ rtl/core/q2e_pkg.sv @@
// q2e_pkg: shared types, constants and helpers for the quaternion to Euler converter.
// No dependencies; compiled first.
package q2e_pkg;

  localparam int Q_W              = 16;  // quaternion component, Q2.14
  localparam int ANG_W            = 16;  // angle, Q3.13
  localparam int LIMIT_W          = 10;  // degenerate limit register
  localparam int PROD_W           = 32;  // exact 16x16 product
  localparam int SUM_W            = 36;  // doubled sum of products, Q28
  localparam int TERM_W           = 22;  // matrix term, Q16
  localparam int SQ_W             = 2 * TERM_W;
  localparam int RAD_W            = 42;  // radicand m33^2 + m31^2
  localparam int CY_W             = 21;  // floor sqrt of the radicand
  localparam int SQRT_ITERS       = 21;
  localparam int SQRT_PER_STAGE   = 2;
  localparam int SQRT_STAGES      = (SQRT_ITERS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int VEC_W            = 44;  // CORDIC vector component
  localparam int ZW               = 36;  // CORDIC angle accumulator, 2^-30 rad
  localparam int CORDIC_PRESCALE  = 18;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_MAX          = 25736;

  localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);
  localparam logic signed [ZW-1:0]    PI_Q30  = ZW'(64'sd3373259426);

  typedef struct packed {
    logic signed [TERM_W-1:0] m31;
    logic signed [TERM_W-1:0] m32;
    logic signed [TERM_W-1:0] m33;
    logic signed [TERM_W-1:0] m12;
    logic signed [TERM_W-1:0] m22;
    logic signed [TERM_W-1:0] m11;
    logic signed [TERM_W-1:0] m21;
  } term_t;

  // Q28 -> Q16, round half up
  function automatic logic signed [TERM_W-1:0] round_q16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + SUM_W'(2048)) >>> 12;
    return t[TERM_W-1:0];
  endfunction

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = ZW'(64'sd843314857);
      1:       r = ZW'(64'sd497837829);
      2:       r = ZW'(64'sd263043837);
      3:       r = ZW'(64'sd133525159);
      4:       r = ZW'(64'sd67021687);
      5:       r = ZW'(64'sd33543516);
      6:       r = ZW'(64'sd16775851);
      7:       r = ZW'(64'sd8388437);
      8:       r = ZW'(64'sd4194283);
      9:       r = ZW'(64'sd2097149);
      default: r = (i > 30) ? '0 : (ZW'(1) <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/q2e_in_if.sv @@
// q2e_in_if: request channel carrying one quaternion.
// Depends on q2e_pkg.
interface q2e_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [q2e_pkg::Q_W-1:0]     qx;
  logic signed [q2e_pkg::Q_W-1:0]     qy;
  logic signed [q2e_pkg::Q_W-1:0]     qz;
  logic signed [q2e_pkg::Q_W-1:0]     qw;
  modport source (output valid, qx, qy, qz, qw, input ready);
  modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

@@ rtl/core/q2e_out_if.sv @@
// q2e_out_if: result channel carrying three Euler angles and the gimbal-lock flag.
// Depends on q2e_pkg.
interface q2e_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [q2e_pkg::ANG_W-1:0]   angle_x;
  logic signed [q2e_pkg::ANG_W-1:0]   angle_y;
  logic signed [q2e_pkg::ANG_W-1:0]   angle_z;
  logic                               degenerate;
  modport source (output valid, angle_x, angle_y, angle_z, degenerate, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, degenerate, output ready);
endinterface

@@ rtl/core/q2e_cordic.sv @@
// q2e_cordic: pipelined vectoring CORDIC atan2, one iteration per stage.
// Depends on q2e_pkg. Input register, iteration stages and output register all advance on en.
module q2e_cordic #(
  parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [q2e_pkg::TERM_W-1:0]  y_in,
  input  logic signed [q2e_pkg::TERM_W-1:0]  x_in,
  output logic signed [q2e_pkg::ANG_W-1:0]   angle
);
  import q2e_pkg::*;

  logic signed [VEC_W-1:0] vx_r [0:STEPS];
  logic signed [VEC_W-1:0] vy_r [0:STEPS];
  logic signed [ZW-1:0]    z_r  [0:STEPS];
  logic                    zf_r [0:STEPS];
  logic signed [ANG_W-1:0] angle_r;

  logic signed [VEC_W-1:0] xe_nxt, ye_nxt;
  logic signed [ZW-1:0]    base_nxt;

  // Left half-plane: rotate by pi first
  always_comb begin
    xe_nxt   = VEC_W'(x_in);
    ye_nxt   = VEC_W'(y_in);
    base_nxt = '0;
    if (x_in < 0) begin
      xe_nxt   = -xe_nxt;
      ye_nxt   = -ye_nxt;
      base_nxt = (y_in >= 0) ? PI_Q30 : -PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= xe_nxt <<< CORDIC_PRESCALE;
      vy_r[0] <= ye_nxt <<< CORDIC_PRESCALE;
      z_r[0]  <= base_nxt;
      zf_r[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] + atan_step(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] - atan_step(i);
        end
      end
    end
  end

  logic signed [ZW-1:0] rnd_nxt;
  logic signed [ANG_W-1:0] angle_nxt;

  always_comb begin
    rnd_nxt = (z_r[STEPS] + ZW'(65536)) >>> 17;
    if (rnd_nxt > ZW'(ANG_MAX))
      rnd_nxt = ZW'(ANG_MAX);
    else if (rnd_nxt < -ZW'(ANG_MAX))
      rnd_nxt = -ZW'(ANG_MAX);
    angle_nxt = zf_r[STEPS] ? '0 : rnd_nxt[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

@@ rtl/core/quaternion_to_euler.sv @@
// Quaternion (Q2.14) to XYZ Euler angles (Q3.13 radians) with gimbal-lock detection.
// Pipeline: products, matrix terms, squares, radicand, square-root stages, branch select, CORDIC.
// Throughput: one request per cycle while the output is not stalled; the sqrt and CORDIC are unrolled into stages.
// A stalled output holds the whole pipe; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipe and clears degenerate_limit to 0.
// Depends on q2e_pkg, q2e_in_if, q2e_out_if and q2e_cordic.
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  q2e_in_if.sink                        in_req,
  q2e_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [q2e_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import q2e_pkg::*;

  localparam int CL    = CORDIC_STEPS + 2;       // CORDIC unit latency
  localparam int TP    = SQRT_STAGES + 3;        // term pipe depth
  localparam int DEPTH = 4 + SQRT_STAGES + 1 + CL;

  // Global stall: every stage moves when the output slot is free or being taken.
  logic adv;
  logic valid_r [0:DEPTH-1];
  logic [LIMIT_W-1:0] limit_r;

  assign adv          = out_res.ready || !valid_r[DEPTH-1];
  assign in_req.ready = adv;
  assign out_res.valid = valid_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) valid_r[i] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_req.valid;
      for (int i = 1; i < DEPTH; i++) valid_r[i] <= valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Stage 1: exact products, Q28
  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, xz_r, yw_r, yz_r, xw_r, xy_r, zw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= PROD_W'(in_req.qx) * PROD_W'(in_req.qx);
      yy_r <= PROD_W'(in_req.qy) * PROD_W'(in_req.qy);
      zz_r <= PROD_W'(in_req.qz) * PROD_W'(in_req.qz);
      xz_r <= PROD_W'(in_req.qx) * PROD_W'(in_req.qz);
      yw_r <= PROD_W'(in_req.qy) * PROD_W'(in_req.qw);
      yz_r <= PROD_W'(in_req.qy) * PROD_W'(in_req.qz);
      xw_r <= PROD_W'(in_req.qx) * PROD_W'(in_req.qw);
      xy_r <= PROD_W'(in_req.qx) * PROD_W'(in_req.qy);
      zw_r <= PROD_W'(in_req.qz) * PROD_W'(in_req.qw);
    end
  end

  // Stage 2: matrix terms rounded to Q16
  term_t tp_r [0:TP-1];
  term_t t_nxt;

  always_comb begin
    t_nxt.m31 = round_q16((SUM_W'(xz_r) + SUM_W'(yw_r)) <<< 1);
    t_nxt.m32 = round_q16((SUM_W'(yz_r) - SUM_W'(xw_r)) <<< 1);
    t_nxt.m33 = round_q16(ONE_Q28 - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1));
    t_nxt.m12 = round_q16((SUM_W'(xy_r) + SUM_W'(zw_r)) <<< 1);
    t_nxt.m22 = round_q16(ONE_Q28 - ((SUM_W'(xx_r) + SUM_W'(zz_r)) <<< 1));
    t_nxt.m11 = round_q16(ONE_Q28 - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1));
    t_nxt.m21 = round_q16((SUM_W'(xy_r) - SUM_W'(zw_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_r[0] <= t_nxt;
      for (int i = 1; i < TP; i++) tp_r[i] <= tp_r[i-1];
    end
  end

  // Stage 3: squares; stage 4: radicand
  logic signed [SQ_W-1:0] sq31_r, sq33_r;
  logic [RAD_W-1:0] rv_r  [0:SQRT_STAGES];
  logic [RAD_W-1:0] res_r [0:SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq31_r   <= SQ_W'(tp_r[0].m31) * SQ_W'(tp_r[0].m31);
      sq33_r   <= SQ_W'(tp_r[0].m33) * SQ_W'(tp_r[0].m33);
      rv_r[0]  <= sq31_r[RAD_W-1:0] + sq33_r[RAD_W-1:0];
      res_r[0] <= '0;
    end
  end

  // Stages 5..: digit-by-digit square root, two result bits per stage (one in the last)
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    logic [RAD_W-1:0] v_nxt, r_nxt;

    always_comb begin
      logic [RAD_W-1:0] bit_v;
      logic [RAD_W-1:0] trial;
      v_nxt = rv_r[s];
      r_nxt = res_r[s];
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        if (s * SQRT_PER_STAGE + j < SQRT_ITERS) begin
          bit_v = RAD_W'(1) << (2 * (SQRT_ITERS - 1 - (s * SQRT_PER_STAGE + j)));
          trial = r_nxt + bit_v;
          if (v_nxt >= trial) begin
            v_nxt = v_nxt - trial;
            r_nxt = (r_nxt >> 1) + bit_v;
          end else begin
            r_nxt = r_nxt >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rv_r[s+1]  <= v_nxt;
        res_r[s+1] <= r_nxt;
      end
    end
  end

  // Branch select: degenerate when cy <= 4 * limit; a zero vector makes angle_y 0
  logic [CY_W-1:0] cy;
  logic            deg_nxt;
  term_t           ts;
  logic signed [TERM_W-1:0] axy_r, axx_r, ayy_r, ayx_r, azy_r, azx_r;
  logic deg_r [0:CL];

  assign cy      = res_r[SQRT_STAGES][CY_W-1:0];
  assign ts      = tp_r[TP-1];
  assign deg_nxt = cy <= CY_W'({limit_r, 2'b00});

  always_ff @(posedge clk) begin
    if (adv) begin
      axy_r    <= -ts.m32;
      axx_r    <= TERM_W'(cy);
      ayy_r    <= deg_nxt ? '0 : ts.m31;
      ayx_r    <= deg_nxt ? '0 : ts.m33;
      azy_r    <= deg_nxt ? -ts.m21 : ts.m12;
      azx_r    <= deg_nxt ? ts.m11 : ts.m22;
      deg_r[0] <= deg_nxt;
      for (int i = 1; i <= CL; i++) deg_r[i] <= deg_r[i-1];
    end
  end

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
    .clk(clk), .en(adv), .y_in(axy_r), .x_in(axx_r), .angle(out_res.angle_x)
  );
  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk(clk), .en(adv), .y_in(ayy_r), .x_in(ayx_r), .angle(out_res.angle_y)
  );
  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk(clk), .en(adv), .y_in(azy_r), .x_in(azx_r), .angle(out_res.angle_z)
  );

  assign out_res.degenerate = deg_r[CL];

`ifndef SYNTHESIS
  a_deg_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.degenerate |-> out_res.angle_y == '0)
    else $error("degenerate result with nonzero angle_y");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.angle_x <= ANG_W'(ANG_MAX)) &&
                      (out_res.angle_x >= -ANG_W'(ANG_MAX)))
    else $error("angle_x out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ bench/q2e_tb_pkg.sv @@
// Testbench-side package: request record for the quaternion to Euler bench.
// Depends on q2e_pkg.
`timescale 1ns / 100ps
package q2e_tb_pkg;
  import q2e_pkg::*;

  typedef struct packed {
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
    logic signed [Q_W-1:0] qz;
    logic signed [Q_W-1:0] qw;
  } quat_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] ax;
    logic signed [ANG_W-1:0] ay;
    logic signed [ANG_W-1:0] az;
    logic                    degen;
  } euler_t;
endpackage

@@ bench/testbench.sv @@
// Self-checking bench for quaternion_to_euler: random and corner quaternions,
// angles predicted in fixed point and compared per field. Depends on q2e_pkg,
// q2e_tb_pkg, q2e_in_if, q2e_out_if and the DUT.
`timescale 1ns / 100ps
module testbench;
  import q2e_pkg::*;
  import q2e_tb_pkg::*;

  localparam int STEPS    = CORDIC_STEPS_DEF;
  localparam int LATENCY  = 4 + 11 + 1 + STEPS + 2;
  localparam int WD_LIMIT = 2000;
  localparam longint PI30 = 64'sd3373259426;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  q2e_in_if  in_req();
  q2e_out_if out_res();

  quaternion_to_euler #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  quat_t  pending_q[$];     // requests waiting for the driver
  euler_t angles_due[$];    // predicted angles, oldest first
  logic [LIMIT_W-1:0] limit_shadow = '0;
  int  errors = 0;
  bit  quiet = 1'b0;        // last part of the run: no idling
  bit  hold_sink = 1'b0;    // long receiver hold-off
  int  hold_cycles = 0;
  int  idle_in = 0, idle_out = 0;
  int  wd = 0;

  // Floor-style arithmetic shift for signed 64-bit values.
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q28_to_q16(longint v);
    return sra(v + 2048, 12);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arctan_unit(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return (i > 30) ? 0 : (64'sd1 << (30 - i));
    endcase
  endfunction

  // Vectoring CORDIC atan2, Q3.13 result clamped to +-pi.
  function automatic logic signed [ANG_W-1:0] vec_atan2(longint y, longint x);
    longint base, vx, vy, acc, nx, r;
    base = 0;
    acc = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      base = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    vx = x * 262144;
    vy = y * 262144;
    for (int i = 0; i < STEPS; i++) begin
      if (vy >= 0) begin
        nx = vx + sra(vy, i);
        vy = vy - sra(vx, i);
        acc += arctan_unit(i);
      end else begin
        nx = vx - sra(vy, i);
        vy = vy + sra(vx, i);
        acc -= arctan_unit(i);
      end
      vx = nx;
    end
    r = sra(acc + base + 65536, 17);
    if (r > ANG_MAX) r = ANG_MAX;
    if (r < -ANG_MAX) r = -ANG_MAX;
    return r[ANG_W-1:0];
  endfunction

  function automatic euler_t quat_to_euler(quat_t q, logic [LIMIT_W-1:0] lim);
    longint x, y, z, w, m31, m32, m33, m12, m22, m11, m21, cy;
    euler_t e;
    x = longint'(q.qx); y = longint'(q.qy); z = longint'(q.qz); w = longint'(q.qw);
    m31 = q28_to_q16(2 * (x * z + y * w));
    m32 = q28_to_q16(2 * (y * z - x * w));
    m33 = q28_to_q16((64'sd1 << 28) - 2 * (x * x + y * y));
    cy  = floor_sqrt(m33 * m33 + m31 * m31);
    e.ax = vec_atan2(-m32, cy);
    if (cy > 4 * longint'(lim)) begin
      m12 = q28_to_q16(2 * (x * y + z * w));
      m22 = q28_to_q16((64'sd1 << 28) - 2 * (x * x + z * z));
      e.ay = vec_atan2(m31, m33);
      e.az = vec_atan2(m12, m22);
      e.degen = 1'b0;
    end else begin
      m11 = q28_to_q16((64'sd1 << 28) - 2 * (y * y + z * z));
      m21 = q28_to_q16(2 * (x * y - z * w));
      e.ay = '0;
      e.az = vec_atan2(-m21, m11);
      e.degen = 1'b1;
    end
    return e;
  endfunction

  function automatic quat_t mk(int a, int b, int c, int d);
    quat_t q;
    q.qx = a[15:0]; q.qy = b[15:0]; q.qz = c[15:0]; q.qw = d[15:0];
    return q;
  endfunction

  // Random unit-ish quaternion; sometimes pushed toward gimbal lock
  // (pitch near +-90 deg makes m31 and m33 small).
  function automatic quat_t rand_quat();
    quat_t q;
    int k, a, b;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      q.qx = 16'($urandom); q.qy = 16'($urandom);
      q.qz = 16'($urandom); q.qw = 16'($urandom);
    end else if (k < 5) begin
      // |x| = |w|, |y| = |z| roughly: m32 near +-1 and cy near 0 when a is near 11585
      a = $urandom_range(0, 11585);
      b = 11585 - a;
      q.qx = 16'(a + $urandom_range(0, 6) - 3);
      q.qw = 16'(($urandom_range(0, 1) ? a : -a) + $urandom_range(0, 6) - 3);
      q.qy = 16'(b + $urandom_range(0, 6) - 3);
      q.qz = 16'((q.qx == q.qw ? -b : b) + $urandom_range(0, 6) - 3);
    end else begin
      q.qx = 16'($signed(16'($urandom_range(0, 16384))) - 8192);
      q.qy = 16'($signed(16'($urandom_range(0, 16384))) - 8192);
      q.qz = 16'($signed(16'($urandom_range(0, 16384))) - 8192);
      q.qw = 16'($signed(16'($urandom_range(0, 32768))) - 16384);
    end
    return q;
  endfunction

  // Write the limit register with the bench idle.
  task automatic set_limit(logic [LIMIT_W-1:0] v);
    while (pending_q.size() != 0 || angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = v;
  endtask

  // Driver: offers queued requests, with random bursts of idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_req.qx <= '0; in_req.qy <= '0; in_req.qz <= '0; in_req.qw <= '0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        angles_due.push_back(quat_to_euler(pending_q.pop_front(), limit_shadow));
      end
      if (!(in_req.valid && !in_req.ready)) begin
        if (idle_in > 0) begin
          idle_in--;
          in_req.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          idle_in = $urandom_range(0, 3);
          in_req.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_req.valid <= 1'b1;
          {in_req.qx, in_req.qy, in_req.qz, in_req.qw} <= pending_q[0];
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest prediction; also drives ready.
  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (angles_due.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          exp_e = angles_due.pop_front();
          if (out_res.angle_x !== exp_e.ax) begin
            $error("angle_x exp %0d got %0d", exp_e.ax, out_res.angle_x); errors++;
          end
          if (out_res.angle_y !== exp_e.ay) begin
            $error("angle_y exp %0d got %0d", exp_e.ay, out_res.angle_y); errors++;
          end
          if (out_res.angle_z !== exp_e.az) begin
            $error("angle_z exp %0d got %0d", exp_e.az, out_res.angle_z); errors++;
          end
          if (out_res.degenerate !== exp_e.degen) begin
            $error("degenerate exp %0d got %0d", exp_e.degen, out_res.degenerate);
            errors++;
          end
        end
      end
      if (hold_sink && hold_cycles < 120) begin
        hold_cycles++;
        out_res.ready <= 1'b0;
      end else if (idle_out > 0) begin
        idle_out--;
        out_res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_out = $urandom_range(0, 3);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || cfg_we)
      wd <= 0;
    else
      wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, axes, extremes, zero vector, gimbal lock.
    pending_q.push_back(mk(0, 0, 0, 16384));
    pending_q.push_back(mk(0, 0, 0, 0));
    pending_q.push_back(mk(16384, 0, 0, 0));
    pending_q.push_back(mk(0, 16384, 0, 0));
    pending_q.push_back(mk(0, 0, 16384, 0));
    pending_q.push_back(mk(0, 0, 0, -16384));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768));
    pending_q.push_back(mk(32767, 32767, 32767, 32767));
    pending_q.push_back(mk(-32768, 32767, -32768, 32767));
    pending_q.push_back(mk(32767, 0, 0, -32768));
    pending_q.push_back(mk(11585, 11585, -11585, 11585));
    pending_q.push_back(mk(11585, -11585, 11585, 11585));
    pending_q.push_back(mk(11585, 0, 0, -11585));
    pending_q.push_back(mk(-1, -1, -1, -1));
    pending_q.push_back(mk(8192, 8192, 8192, 8192));
    pending_q.push_back(mk(0, 11585, 0, 11585));
    pending_q.push_back(mk(0, -11585, 0, 11585));

    // Random, across several limit settings; extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: set_limit('1);
        2: set_limit(LIMIT_W'($urandom_range(1, 1022)));
        3: set_limit('0);
        4: set_limit(LIMIT_W'($urandom_range(1, 64)));
        default: ;
      endcase
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        hold_cycles = 0;
        hold_sink = 1'b1;
      end
      if (phase == 4) quiet = 1'b1;
      for (int n = 0; n < 110; n++) pending_q.push_back(rand_quat());
    end

    while (pending_q.size() != 0 || angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && angles_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

@@ quaternion_to_euler.f @@
rtl/core/q2e_pkg.sv
rtl/core/q2e_in_if.sv
rtl/core/q2e_out_if.sv
rtl/core/q2e_cordic.sv
rtl/core/quaternion_to_euler.sv
bench/q2e_tb_pkg.sv
bench/testbench.sv
